### design/bilateral_filter_5x5_unit_defines.svh
`ifndef BILATERAL_FILTER_5X5_UNIT_DEFINES_SVH
`define BILATERAL_FILTER_5X5_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low
`define BFU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on clk, off while rst_n is low
`define BFU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/bfu_pkg.sv
package bfu_pkg;

    localparam int WINDOW_DEF   = 5;
    localparam int MAX_LINE_DEF = 2048;
    localparam int NUM_CH       = 3;
    localparam int PIX_W        = 8;
    localparam int WGT_W        = 16;
    localparam int TAB_AW       = 8;
    localparam int CFG_AW       = 3;
    localparam int CFG_DW       = 16;
    localparam int LINE_W_W     = 12;
    localparam int COL_W        = 11;
    localparam int ROW_W        = 16;
    localparam int NUM_SW       = 6;

    localparam logic [CFG_AW-1:0] CFG_LINE_WIDTH = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_CHAN_COUNT = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SW_BASE    = 3'd2;

    // spatial weight classes by squared tap distance
    localparam logic [2:0] SWC_R0   = 3'd0;
    localparam logic [2:0] SWC_R1   = 3'd1;
    localparam logic [2:0] SWC_R2   = 3'd2;
    localparam logic [2:0] SWC_R4   = 3'd3;
    localparam logic [2:0] SWC_R5   = 3'd4;
    localparam logic [2:0] SWC_R8   = 3'd5;
    localparam logic [2:0] SWC_NONE = 3'd6;

    typedef struct packed {
        logic                    start;
        logic                    tab_we;
        logic [TAB_AW-1:0]       tab_addr;
        logic [WGT_W-1:0]        tab_data;
    } lane_ctl_t;

    typedef struct packed {
        logic                    done;
        logic [PIX_W-1:0]        result;
    } lane_sts_t;

    function automatic logic [2:0] sw_class(input int i, input int j, input int rad);
        int d2;
        d2 = (i - rad) * (i - rad) + (j - rad) * (j - rad);
        case (d2)
            0:       return SWC_R0;
            1:       return SWC_R1;
            2:       return SWC_R2;
            4:       return SWC_R4;
            5:       return SWC_R5;
            8:       return SWC_R8;
            default: return SWC_NONE;
        endcase
    endfunction

endpackage

### design/bfu_lane.sv
`include "bilateral_filter_5x5_unit_defines.svh"

module bfu_lane #(
    parameter int TAPS = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bfu_pkg::lane_ctl_t         ctl,
    input  logic [bfu_pkg::PIX_W-1:0]  taps [TAPS],
    input  logic [bfu_pkg::WGT_W-1:0]  sw   [TAPS],
    input  logic [bfu_pkg::PIX_W-1:0]  cv,
    output bfu_pkg::lane_sts_t         sts
);
    import bfu_pkg::*;

    localparam int TW    = $clog2(TAPS);
    localparam int DEN_W = WGT_W + TW;
    localparam int NUM_W = DEN_W + PIX_W;
    localparam int QB_W  = $clog2(PIX_W);

    typedef enum logic [3:0] {
        L_IDLE  = 4'b0001,
        L_RUN   = 4'b0010,
        L_DRAIN = 4'b0100,
        L_DIV   = 4'b1000
    } lane_state_t;

    lane_state_t          st_reg, st_next;
    logic [TW-1:0]        tap_reg;
    logic [WGT_W-1:0]     tab_mem [2**TAB_AW];
    logic [WGT_W-1:0]     wr_q;
    logic                 v1_reg, v2_reg;
    logic [PIX_W-1:0]     tv1_reg, tv2_reg;
    logic [WGT_W-1:0]     sw1_reg, w2_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [NUM_W-1:0]     num_reg, rem_reg, rem_next, trial;
    logic [QB_W-1:0]      bit_reg;
    logic [PIX_W-1:0]     q_reg, q_next;
    logic                 done_reg;
    logic [PIX_W-1:0]     tv, diff;
    logic [2*WGT_W-1:0]   wprod;

    assign tv    = taps[tap_reg];
    assign diff  = (tv > cv) ? (tv - cv) : (cv - tv);
    assign wprod = sw1_reg * wr_q;
    assign trial = NUM_W'(den_reg) << bit_reg;

    // range table copy; read data registered
    always_ff @(posedge clk)
    begin
        if (ctl.tab_we)
        begin
            tab_mem[ctl.tab_addr] <= ctl.tab_data;
        end
        wr_q <= tab_mem[diff];
    end

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        if (rem_reg >= trial)
        begin
            rem_next       = rem_reg - trial;
            q_next[bit_reg] = 1'b1;
        end
    end

    // the divider always runs its full length so all lanes finish together
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            L_IDLE:  if (ctl.start) st_next = L_RUN;
            L_RUN:   if (tap_reg == TW'(TAPS - 1)) st_next = L_DRAIN;
            L_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    st_next = L_DIV;
                end
            end
            L_DIV:   if (bit_reg == '0) st_next = L_IDLE;
            default: st_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= L_IDLE;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            v1_reg   <= (st_reg == L_RUN);
            v2_reg   <= v1_reg;
            done_reg <= (st_reg == L_DIV) && (st_next == L_IDLE);
        end
    end

    always_ff @(posedge clk)
    begin
        tv1_reg <= tv;
        sw1_reg <= sw[tap_reg];
        tv2_reg <= tv1_reg;
        w2_reg  <= wprod[2*WGT_W-1:WGT_W];
        case (st_reg)
            L_IDLE:
            begin
                tap_reg <= '0;
                num_reg <= '0;
                den_reg <= '0;
            end
            L_RUN:
            begin
                tap_reg <= tap_reg + TW'(1);
            end
            L_DRAIN:
            begin
                rem_reg <= num_reg;
                bit_reg <= QB_W'(PIX_W - 1);
                q_reg   <= (den_reg == '0) ? cv : '0;
            end
            L_DIV:
            begin
                // zero weight sum keeps the centre value
                if (den_reg != '0)
                begin
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                end
                bit_reg <= bit_reg - QB_W'(1);
            end
            default: ;
        endcase
        if (v2_reg)
        begin
            num_reg <= num_reg + NUM_W'(tv2_reg) * NUM_W'(w2_reg);
            den_reg <= den_reg + DEN_W'(w2_reg);
        end
    end

    assign sts.done   = done_reg;
    assign sts.result = q_reg;

    `BFU_ASSERT_IMPL(a_start_idle, ctl.start, st_reg == L_IDLE)
    `BFU_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg)
    `BFU_ASSERT_IMPL(a_rem_below, done_reg && den_reg != '0, rem_reg < NUM_W'(den_reg))

endmodule

### design/bfu_merge.sv
module bfu_merge (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [bfu_pkg::PIX_W-1:0]       res [bfu_pkg::NUM_CH],
    input  logic [1:0]                      chan_cnt,
    input  logic [bfu_pkg::COL_W-1:0]       col,
    input  logic [bfu_pkg::ROW_W-1:0]       row,
    output logic                            free,
    output logic [55:0]                     m_tdata,  // out_col, out_row, out_c0..out_c2
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import bfu_pkg::*;

    logic             valid_reg;
    logic [55:0]      data_reg;
    logic [PIX_W-1:0] ch_val [NUM_CH];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            ch_val[c] = (2'(c) < chan_cnt) ? res[c] : '0;
        end
    end

    assign free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {5'd0, ch_val[2], ch_val[1], ch_val[0], row, col};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

### design/bilateral_filter_5x5_unit.sv
// Bilateral filter, square window, up to three 8-bit channels.
// Input stream s_*: one beat per pixel or range table load, chosen by tuser[0].
// A pixel beat with tuser[1] set restarts column and row at zero.
// Output stream m_*: one beat per interior centre pixel, raster order, the
// centre lagging the incoming pixel by WINDOW/2 rows and columns.
// cfg_*: register writes (line width, channel count, six spatial weights),
// only while no pixel is in flight.
// A pixel that gives no result returns to idle after the window load. A pixel
// that gives a result then goes through the calc and hand-off states:
// each channel lane walks the taps through a weight multiplier and
// weighted-sum accumulators, then an 8-step restoring divider.
// The three channel lanes run side by side.
// The finished beat sits in an output register, so the next pixel is taken
// while it waits; a stalled receiver holds the block only once a second
// result is ready.
// Reset clears counters, window and registers to defaults; the line buffers
// and range table hold garbage until written, and no clearing pass runs.
module bilateral_filter_5x5_unit #(
    parameter int WINDOW   = bfu_pkg::WINDOW_DEF,
    parameter int MAX_LINE = bfu_pkg::MAX_LINE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [47:0]                 s_tdata,  // pixel_c0, pixel_c1, pixel_c2, table_index, table_weight
    input  logic [1:0]                  s_tuser,  // opcode, frame_start
    input  logic                        s_tvalid,
    output logic                        s_tready,
    output logic [55:0]                 m_tdata,  // out_col, out_row, out_c0, out_c1, out_c2
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        cfg_we,
    input  logic [bfu_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [bfu_pkg::CFG_DW-1:0]  cfg_data
);
    import bfu_pkg::*;

    localparam int RAD    = WINDOW / 2;
    localparam int SLOTS  = 2 * RAD;
    localparam int SPAN   = SLOTS + 1;
    localparam int TAPS   = WINDOW * WINDOW;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(MAX_LINE);
    localparam int WCMP   = (CNT_W + 1 > LINE_W_W) ? CNT_W + 1 : LINE_W_W;
    localparam int COLX   = (CNT_W > COL_W) ? CNT_W : COL_W;
    localparam int PXW    = NUM_CH * PIX_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_CALC = 4'b0100,
        S_HAND = 4'b1000
    } top_state_t;

    top_state_t           st_reg, st_next;
    logic [LINE_W_W-1:0]  line_width_reg;
    logic [1:0]           chan_cnt_reg;
    logic [WGT_W-1:0]     sw_reg [NUM_SW];
    logic [CNT_W-1:0]     col_reg, col_cur, col_pix_reg;
    logic [ROW_W-1:0]     row_reg, row_cur, row_pix_reg;
    logic [PXW-1:0]       px_reg;
    logic                 emit_reg;
    logic [COL_W-1:0]     ocol_reg;
    logic [ROW_W-1:0]     orow_reg;
    logic [PXW-1:0]       rd_q [SLOTS];
    logic [PXW-1:0]       win_reg [SPAN][SPAN];
    logic [WCMP-1:0]      wlim, col_inc;
    logic [COLX-1:0]      col_x;
    logic                 acc, acc_pix, acc_tab;
    logic [CFG_AW-1:0]    sw_idx;
    logic [WGT_W-1:0]     sw_tap [TAPS];
    logic [PIX_W-1:0]     lane_taps [NUM_CH][TAPS];
    lane_ctl_t            lane_ctl;
    lane_sts_t            lane_sts [NUM_CH];
    logic [PIX_W-1:0]     lane_res [NUM_CH];
    logic                 merge_free, merge_load;

    assign s_tready = (st_reg == S_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign acc_pix  = acc && !s_tuser[0];
    assign acc_tab  = acc && s_tuser[0];

    // config registers
    assign sw_idx = cfg_addr - CFG_SW_BASE;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= 12'd640;
            chan_cnt_reg   <= 2'd3;
            sw_reg[0]      <= 16'd65535;
            sw_reg[1]      <= 16'd65529;
            sw_reg[2]      <= 16'd65523;
            sw_reg[3]      <= 16'd65512;
            sw_reg[4]      <= 16'd65506;
            sw_reg[5]      <= 16'd65488;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_LINE_WIDTH: line_width_reg <= cfg_data[LINE_W_W-1:0];
                CFG_CHAN_COUNT: chan_cnt_reg   <= cfg_data[1:0];
                default:        sw_reg[sw_idx] <= cfg_data;
            endcase
        end
    end

    // position of the incoming pixel
    assign col_cur = s_tuser[1] ? '0 : col_reg;
    assign row_cur = s_tuser[1] ? '0 : row_reg;
    assign wlim    = (WCMP'(line_width_reg) >= WCMP'(MAX_LINE)) ?
                     WCMP'(MAX_LINE) : WCMP'(line_width_reg);
    assign col_inc = WCMP'(col_cur) + WCMP'(1);
    assign col_x   = COLX'(col_cur) - COLX'(RAD);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (acc_pix) st_next = S_LOAD;
            S_LOAD:  st_next = emit_reg ? S_CALC : S_IDLE;
            S_CALC:  if (lane_sts[0].done) st_next = S_HAND;
            S_HAND:  if (merge_free) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (acc_pix)
            begin
                if (col_inc >= wlim)
                begin
                    col_reg <= '0;
                    row_reg <= row_cur + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_inc[CNT_W-1:0];
                    row_reg <= row_cur;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_pix)
        begin
            px_reg      <= s_tdata[PXW-1:0];
            col_pix_reg <= col_cur;
            row_pix_reg <= row_cur;
            emit_reg    <= (row_cur >= ROW_W'(SLOTS)) && (col_cur >= CNT_W'(SLOTS));
            ocol_reg    <= col_x[COL_W-1:0];
            orow_reg    <= row_cur - ROW_W'(RAD);
        end
    end

    // line buffers: one memory per stored row, read at the accept beat
    for (genvar s = 0; s < SLOTS; s++)
    begin : g_line
        logic [PXW-1:0] line_mem [MAX_LINE];
        always_ff @(posedge clk)
        begin
            if (acc_pix)
            begin
                rd_q[s] <= line_mem[col_cur];
            end
            if ((st_reg == S_LOAD) && (row_pix_reg[SLOT_W-1:0] == SLOT_W'(s)))
            begin
                line_mem[col_pix_reg] <= px_reg;
            end
        end
    end

    // window shift; oldest stored row lands on top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SPAN; k++)
            begin
                for (int j = 0; j < SPAN; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else if (st_reg == S_LOAD)
        begin
            for (int k = 0; k < SPAN; k++)
            begin
                for (int j = 0; j < SPAN - 1; j++)
                begin
                    win_reg[k][j] <= win_reg[k][j + 1];
                end
            end
            for (int k = 0; k < SLOTS; k++)
            begin
                win_reg[k][SPAN-1] <= rd_q[row_pix_reg[SLOT_W-1:0] + SLOT_W'(k)];
            end
            win_reg[SPAN-1][SPAN-1] <= px_reg;
        end
    end

    // per-tap spatial weight and lane tap vectors
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                case (sw_class(i, j, RAD))
                    SWC_R0:  sw_tap[i*WINDOW+j] = sw_reg[0];
                    SWC_R1:  sw_tap[i*WINDOW+j] = sw_reg[1];
                    SWC_R2:  sw_tap[i*WINDOW+j] = sw_reg[2];
                    SWC_R4:  sw_tap[i*WINDOW+j] = sw_reg[3];
                    SWC_R5:  sw_tap[i*WINDOW+j] = sw_reg[4];
                    SWC_R8:  sw_tap[i*WINDOW+j] = sw_reg[5];
                    default: sw_tap[i*WINDOW+j] = '0;
                endcase
                for (int c = 0; c < NUM_CH; c++)
                begin
                    lane_taps[c][i*WINDOW+j] = win_reg[i][j][c*PIX_W +: PIX_W];
                end
            end
        end
    end

    assign lane_ctl.start    = (st_reg == S_LOAD) && emit_reg;
    assign lane_ctl.tab_we   = acc_tab;
    assign lane_ctl.tab_addr = s_tdata[31:24];
    assign lane_ctl.tab_data = s_tdata[47:32];

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        bfu_lane #(
            .TAPS (TAPS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl),
            .taps  (lane_taps[c]),
            .sw    (sw_tap),
            .cv    (win_reg[RAD][RAD][c*PIX_W +: PIX_W]),
            .sts   (lane_sts[c])
        );
        assign lane_res[c] = lane_sts[c].result;
    end

    assign merge_load = (st_reg == S_HAND) && merge_free;

    bfu_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (merge_load),
        .res      (lane_res),
        .chan_cnt (chan_cnt_reg),
        .col      (ocol_reg),
        .row      (orow_reg),
        .free     (merge_free),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

### bench/bilateral_filter_5x5_unit_tb.sv
module bilateral_filter_5x5_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfu_pkg::*;

    typedef enum logic {OP_PIXEL = 1'b0, OP_TABLE = 1'b1} op_e;

    typedef struct {
        logic [10:0] col;
        logic [15:0] row;
        logic [7:0]  ch [3];
    } filtered_px_t;

    class filter_scoreboard;
        logic [15:0] regs [8];
        logic [23:0] lines [4][2048];
        logic [23:0] win [5][5];
        logic [15:0] range_tab [256];
        logic [10:0] col_cnt;
        logic [15:0] row_cnt;
        filtered_px_t pending_px [$];
        int n_items;
        int n_results;
        int n_bad;

        function new();
            regs = '{16'd640, 16'd3, 16'd65535, 16'd65529, 16'd65523,
                     16'd65512, 16'd65506, 16'd65488};
            foreach (lines[k, c]) lines[k][c] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            foreach (range_tab[i]) range_tab[i] = '0;
            col_cnt = '0;
            row_cnt = '0;
            n_items = 0;
            n_results = 0;
            n_bad = 0;
        endfunction

        function void set_reg(int idx, logic [15:0] val);
            case (idx)
                0: regs[idx] = {4'd0, val[11:0]};
                1: regs[idx] = {14'd0, val[1:0]};
                default: regs[idx] = val;
            endcase
        endfunction

        function logic [15:0] dist_weight(int d2);
            case (d2)
                0: return regs[CFG_SW_BASE + 0];
                1: return regs[CFG_SW_BASE + 1];
                2: return regs[CFG_SW_BASE + 2];
                4: return regs[CFG_SW_BASE + 3];
                5: return regs[CFG_SW_BASE + 4];
                8: return regs[CFG_SW_BASE + 5];
                default: return 16'd0;
            endcase
        endfunction

        // accepted input beat: update state, queue the filtered pixel if any
        function void note_beat(logic [1:0] user, logic [47:0] data);
            logic [23:0] px;
            logic [23:0] centre;
            int col, row, slot, width;
            longint unsigned num, den, q;
            logic [31:0] prod;
            logic [7:0] tv, cv, diff;
            filtered_px_t r;
            n_items++;
            if (user[0] == OP_TABLE) begin
                range_tab[data[31:24]] = data[47:32];
                return;
            end
            if (user[1]) begin
                col_cnt = '0;
                row_cnt = '0;
            end
            px = data[23:0];
            col = col_cnt;
            row = row_cnt;
            for (int k = 0; k < 5; k++)
                for (int j = 0; j < 4; j++)
                    win[k][j] = win[k][j + 1];
            for (int k = 0; k < 4; k++) begin
                slot = (row + 65536 - 4 + k) % 4;
                win[k][4] = lines[slot][col];
            end
            win[4][4] = px;
            lines[row % 4][col] = px;
            if (row >= 4 && col >= 4) begin
                centre = win[2][2];
                r.col = col - 2;
                r.row = row - 2;
                for (int ch = 0; ch < 3; ch++) begin
                    cv = centre[8*ch +: 8];
                    if (ch >= regs[CFG_CHAN_COUNT]) begin
                        r.ch[ch] = 8'd0;
                        continue;
                    end
                    num = 0;
                    den = 0;
                    for (int i = 0; i < 5; i++)
                        for (int j = 0; j < 5; j++) begin
                            tv = win[i][j][8*ch +: 8];
                            diff = (tv > cv) ? tv - cv : cv - tv;
                            prod = dist_weight((i-2)*(i-2) + (j-2)*(j-2)) * range_tab[diff];
                            num += tv * longint'(prod[31:16]);
                            den += prod[31:16];
                        end
                    if (den == 0)
                        q = cv;
                    else begin
                        q = num / den;
                        if (q > 255) q = 255;
                    end
                    r.ch[ch] = q[7:0];
                end
                pending_px.push_back(r);
            end
            width = regs[CFG_LINE_WIDTH];
            if (width > 2048) width = 2048;
            if (col + 1 >= width) begin
                col_cnt = '0;
                row_cnt = row_cnt + 1;
            end else
                col_cnt = col + 1;
        endfunction

        function void check_beat(logic [55:0] data);
            filtered_px_t e;
            n_results++;
            if (pending_px.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected output beat %h", data);
                return;
            end
            e = pending_px.pop_front();
            if (data[10:0] !== e.col || data[26:11] !== e.row ||
                data[34:27] !== e.ch[0] || data[42:35] !== e.ch[1] ||
                data[50:43] !== e.ch[2]) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch: exp col %0d row %0d c %0d %0d %0d, got col %0d row %0d c %0d %0d %0d",
                             e.col, e.row, e.ch[0], e.ch[1], e.ch[2],
                             data[10:0], data[26:11], data[34:27], data[42:35], data[50:43]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_data;

    filter_scoreboard sb;
    bit no_idle;
    int n_phases;

    bilateral_filter_5x5_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        sb = new();
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        rst_n    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // output side
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_beat(m_tdata);
        end
    end

    task automatic send_beat(op_e op, logic fs, logic [47:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {fs, op};
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        sb.note_beat({fs, op}, data);
    endtask

    task automatic load_entry(logic [7:0] idx, logic [15:0] w);
        send_beat(OP_TABLE, 1'($urandom), {w, idx, 24'($urandom)});
    endtask

    // pause until everything is out, then let in-flight pixels settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_px.size() != 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_regs(int width, int nch, logic [15:0] sw [6]);
        drain();
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_LINE_WIDTH;
        cfg_data <= width;
        @(posedge clk);
        sb.set_reg(CFG_LINE_WIDTH, width);
        cfg_addr <= CFG_CHAN_COUNT;
        cfg_data <= nch;
        @(posedge clk);
        sb.set_reg(CFG_CHAN_COUNT, nch);
        for (int i = 0; i < 6; i++)
        begin
            cfg_addr <= CFG_SW_BASE + i;
            cfg_data <= sw[i];
            @(posedge clk);
            sb.set_reg(CFG_SW_BASE + i, sw[i]);
        end
        cfg_we <= 1'b0;
        n_phases++;
    endtask

    function automatic logic [7:0] near(logic [7:0] base);
        int v;
        v = int'(base) + $urandom_range(0, 16) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v;
    endfunction

    task automatic send_frame(int width, int rows, bit noisy);
        logic [23:0] base;
        logic [23:0] px;
        logic [23:0] junk;
        base = $urandom;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < width; c++)
            begin
                if (noisy && $urandom_range(0, 150) == 0)
                    load_entry($urandom, $urandom);
                if ($urandom_range(0, 40) == 0)
                    base = $urandom;
                if ($urandom_range(0, 3) == 0)
                    px = $urandom;
                else
                    px = {near(base[23:16]), near(base[15:8]), near(base[7:0])};
                junk = $urandom;
                send_beat(OP_PIXEL, (r == 0 && c == 0) ||
                          (noisy && $urandom_range(0, 400) == 0), {junk, px});
            end
    endtask

    initial
    begin
        logic [15:0] sw [6];
        int w, rows;
        @(posedge rst_n);
        @(posedge clk);
        n_phases = 0;
        no_idle = 1'b0;
        // fill the whole range table first; steep falloff with distance
        for (int i = 0; i < 256; i++)
            load_entry(i, (i == 0) ? 16'hFFFF : (i < 64 ? 16'($urandom) : 16'($urandom_range(0, 300))));

        sw = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        write_regs(5, 3, sw);
        send_frame(5, 5, 1'b0);
        // all-zero spatial weights: the one enabled channel falls back to the centre
        sw = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        write_regs(5, 1, sw);
        send_frame(5, 5, 1'b0);
        // no channels enabled
        sw = '{16'd65535, 16'd65529, 16'd65523, 16'd65512, 16'd65506, 16'd65488};
        write_regs(6, 0, sw);
        send_frame(6, 5, 1'b0);
        load_entry(8'd255, 16'd0);
        load_entry(8'd0, 16'd0);

        while (sb.n_items < 1650)
        begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(5, 14);
            rows = $urandom_range(5, 10);
            foreach (sw[i])
                sw[i] = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 1) * 65535)
                                                    : 16'($urandom);
            write_regs(w, $urandom_range(1, 3), sw);
            no_idle = ($urandom_range(0, 3) == 0);
            send_frame(w, rows, 1'b1);
            no_idle = 1'b0;
            if ($urandom_range(0, 2) == 0)
                load_entry($urandom_range(0, 1) ? 8'd0 : 8'($urandom), $urandom);
        end

        // width register above the line limit clamps to the full line
        sw = '{16'd65535, 16'd40000, 16'd30000, 16'd20000, 16'd10000, 16'd5000};
        write_regs(4095, 3, sw);
        send_frame(60, 1, 1'b0);

        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_px.size() != 0);
        repeat (60) @(posedge clk);
        $display("covered %0d input beats over %0d register settings, %0d filtered pixels checked",
                 sb.n_items, n_phases, sb.n_results);
        if (sb.n_bad == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
